FILE: rtl/dsret_pkg.sv
// Shared types and constants for the dense swap-remove entity table.
package dsret_pkg;

   // Fixed field widths of the request and response items.
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 6;
   localparam int COUNT_W   = 7;
   localparam int ID_PORT_W = 32;

   // Operation carried by a request item.
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD         = 2'd0,
      KIND_REMOVE_ID   = 2'd1,
      KIND_REMOVE_SLOT = 2'd2,
      KIND_LOOKUP      = 2'd3
   } kind_type;

   // Outcome reported with every response item.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE         = 2'd0,
      STATUS_FULL         = 2'd1,
      STATUS_NOT_FOUND    = 2'd2,
      STATUS_SLOT_IGNORED = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWAP,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/dense_swap_remove_entity_table.sv
// Top level of the dense swap-remove entity table.
//
// The table keeps entity identifiers packed in slots 0 to count-1 of a single-port
// synchronous memory, with a live count. One request item is worked on at a time and
// the next is accepted as soon as the sequencer is back in idle, even while the previous
// response item still waits at the output register. An add or a remove by slot goes
// from idle straight to the finish state, through the swap state when the last entry has
// to be moved into the hole. A lookup or a remove by identifier scans the stored entries
// one per cycle through the memory's read port, and a remove by identifier then passes
// through the swap state when the last entry has to be moved. No clearing pass is
// needed after reset: only slots below the count are ever read. The limit on the count
// is the smaller of the max_count register and CAPACITY.
module dense_swap_remove_entity_table
   import dsret_pkg::*;
#(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned ID_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // Configuration port.
   input  logic                 csr_write_enable,
   input  logic [COUNT_W-1:0]   csr_write_data,
   // Request channel.
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [ID_PORT_W-1:0] req_entity_id,
   input  logic [SLOT_W-1:0]    req_slot_index,
   // Response channel.
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]    rsp_result_slot,
   output logic                 rsp_moved_valid,
   output logic [SLOT_W-1:0]    rsp_moved_slot,
   output logic [ID_PORT_W-1:0] rsp_moved_entity,
   output logic [COUNT_W-1:0]   rsp_live_count
);

   // Only the low identifier bits that fit both the port and ID_WIDTH are kept.
   localparam int STORE_W = (ID_WIDTH < ID_PORT_W) ? ID_WIDTH : ID_PORT_W;
   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // Entry memory, registered read data.
   logic [STORE_W-1:0] mem [CAPACITY];
   logic [STORE_W-1:0] rdata_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [STORE_W-1:0] mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;

   // Control and working registers.
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] max_ff;
   kind_type           kind_ff, kind_in;
   logic [STORE_W-1:0] id_ff, id_in;
   logic [COUNT_W-1:0] hole_ff, hole_in;
   logic [COUNT_W-1:0] scan_ff, scan_in;

   // Staged result of the item at work.
   status_type         res_status_ff, res_status_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic               res_moved_valid_ff, res_moved_valid_in;
   logic [SLOT_W-1:0]  res_moved_slot_ff, res_moved_slot_in;
   logic [STORE_W-1:0] res_moved_entity_ff, res_moved_entity_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   status_type         rsp_status_ff;
   logic [SLOT_W-1:0]  rsp_result_slot_ff;
   logic               rsp_moved_valid_ff;
   logic [SLOT_W-1:0]  rsp_moved_slot_ff;
   logic [STORE_W-1:0] rsp_moved_entity_ff;
   logic [COUNT_W-1:0] rsp_live_count_ff;

   logic [COUNT_W-1:0] limit;
   logic [COUNT_W-1:0] last;
   logic [COUNT_W-1:0] req_slot;

   // The effective limit never exceeds the capacity of the memory.
   assign limit    = (32'(max_ff) < CAPACITY) ? max_ff : COUNT_W'(CAPACITY);
   assign last     = count_ff - COUNT_W'(1);
   assign req_slot = COUNT_W'(req_slot_index);

   // A new item is taken only while the sequencer is idle.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state, memory accesses and staged result.
   always_comb begin
      state_in            = state_ff;
      count_in            = count_ff;
      kind_in             = kind_ff;
      id_in               = id_ff;
      hole_in             = hole_ff;
      scan_in             = scan_ff;
      res_status_in       = res_status_ff;
      res_slot_in         = res_slot_ff;
      res_moved_valid_in  = res_moved_valid_ff;
      res_moved_slot_in   = res_moved_slot_ff;
      res_moved_entity_in = res_moved_entity_ff;
      mem_we              = 1'b0;
      mem_waddr           = '0;
      mem_wdata           = '0;
      mem_re              = 1'b0;
      mem_raddr           = '0;
      rsp_load            = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in             = kind_type'(req_kind);
               id_in               = req_entity_id[STORE_W-1:0];
               res_status_in       = STATUS_DONE;
               res_slot_in         = '0;
               res_moved_valid_in  = 1'b0;
               res_moved_slot_in   = '0;
               res_moved_entity_in = '0;
               state_in            = ST_FINISH;
               case (kind_type'(req_kind))
                  KIND_ADD: begin
                     if (count_ff >= limit) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        mem_we      = 1'b1;
                        mem_waddr   = AW'(count_ff);
                        mem_wdata   = req_entity_id[STORE_W-1:0];
                        res_slot_in = SLOT_W'(count_ff);
                        count_in    = count_ff + COUNT_W'(1);
                     end
                  end
                  KIND_REMOVE_ID, KIND_LOOKUP: begin
                     // Start the scan at slot zero on a table that is not empty.
                     if (count_ff == '0) begin
                        res_status_in = STATUS_NOT_FOUND;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        scan_in   = '0;
                        state_in  = ST_SCAN;
                     end
                  end
                  KIND_REMOVE_SLOT: begin
                     if (req_slot >= count_ff) begin
                        res_status_in = STATUS_SLOT_IGNORED;
                     end else if (req_slot == last) begin
                        count_in = last;
                     end else begin
                        hole_in   = req_slot;
                        mem_re    = 1'b1;
                        mem_raddr = AW'(last);
                        state_in  = ST_SWAP;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // The read data holds the entry at the scan position.
            if (rdata_ff == id_ff) begin
               if (kind_ff == KIND_LOOKUP) begin
                  res_slot_in = SLOT_W'(scan_ff);
                  state_in    = ST_FINISH;
               end else if (scan_ff == last) begin
                  count_in = last;
                  state_in = ST_FINISH;
               end else begin
                  hole_in   = scan_ff;
                  mem_re    = 1'b1;
                  mem_raddr = AW'(last);
                  state_in  = ST_SWAP;
               end
            end else if (scan_ff == last) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = ST_FINISH;
            end else begin
               scan_in   = scan_ff + COUNT_W'(1);
               mem_re    = 1'b1;
               mem_raddr = AW'(scan_ff + COUNT_W'(1));
            end
         end
         ST_SWAP: begin
            // Move the last entry into the hole.
            mem_we              = 1'b1;
            mem_waddr           = AW'(hole_ff);
            mem_wdata           = rdata_ff;
            res_moved_valid_in  = 1'b1;
            res_moved_slot_in   = SLOT_W'(hole_ff);
            res_moved_entity_in = rdata_ff;
            count_in            = last;
            state_in            = ST_FINISH;
         end
         ST_FINISH: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register empties when its item is taken and fills on a load.
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         max_ff       <= COUNT_W'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_ff <= csr_write_data;
         end
      end
   end

   // Working and staged result registers.
   always_ff @(posedge clock) begin
      kind_ff             <= kind_in;
      id_ff               <= id_in;
      hole_ff             <= hole_in;
      scan_ff             <= scan_in;
      res_status_ff       <= res_status_in;
      res_slot_ff         <= res_slot_in;
      res_moved_valid_ff  <= res_moved_valid_in;
      res_moved_slot_ff   <= res_moved_slot_in;
      res_moved_entity_ff <= res_moved_entity_in;
   end

   // Output payload; the live count is already updated when the result is loaded.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff       <= res_status_ff;
         rsp_result_slot_ff  <= res_slot_ff;
         rsp_moved_valid_ff  <= res_moved_valid_ff;
         rsp_moved_slot_ff   <= res_moved_slot_ff;
         rsp_moved_entity_ff <= res_moved_entity_ff;
         rsp_live_count_ff   <= count_ff;
      end
   end

   // Entry memory. Writes and reads never fall in the same cycle, as the sequencer
   // handles one item at a time, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_slot  = rsp_result_slot_ff;
   assign rsp_moved_valid  = rsp_moved_valid_ff;
   assign rsp_moved_slot   = rsp_moved_slot_ff;
   assign rsp_moved_entity = ID_PORT_W'(rsp_moved_entity_ff);
   assign rsp_live_count   = rsp_live_count_ff;

endmodule

FILE: rtl/dsret_checker.sv
// Port-level assertions for the dense swap-remove entity table, with their bind.
module dsret_checker
   import dsret_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [SLOT_W-1:0]    rsp_result_slot,
   input logic                 rsp_moved_valid,
   input logic [SLOT_W-1:0]    rsp_moved_slot,
   input logic [ID_PORT_W-1:0] rsp_moved_entity,
   input logic [COUNT_W-1:0]   rsp_live_count
);

   // A stalled response item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_slot) && $stable(rsp_moved_valid)
         && $stable(rsp_moved_slot) && $stable(rsp_moved_entity)
         && $stable(rsp_live_count))
      else $error("stalled response item changed");

   // Only a successful removal moves an entry.
   a_move_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moved_valid |-> rsp_status == STATUS_DONE)
      else $error("move reported on a failed operation");

   // A failed operation reports no slot and no move.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |-> !rsp_moved_valid
         && rsp_result_slot == '0 && rsp_moved_slot == '0 && rsp_moved_entity == '0)
      else $error("failed operation carries result fields");

   // The hole that received the last entry lies inside the shrunk table.
   a_move_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moved_valid |-> COUNT_W'(rsp_moved_slot) < rsp_live_count)
      else $error("moved slot beyond live count");

endmodule

bind dense_swap_remove_entity_table dsret_checker u_dsret_checker (.*);
